// ===== rtl/brd_pkg.sv =====
// ----------------------------------------------------------------------------
// brd_pkg
// Shared types and constants for the bus response deframer.
// ----------------------------------------------------------------------------
package brd_pkg;

    localparam int unsigned TimeoutW     = 16;
    localparam int unsigned ByteW        = 8;
    localparam int unsigned ZeroCountW   = 3;
    localparam logic [TimeoutW-1:0] TimeoutReset = 16'd1000;
    localparam logic [TimeoutW-1:0] TicksMax     = 16'hFFFF;
    localparam logic [ZeroCountW-1:0] LeadZeros  = 3'd5;
    localparam logic [ByteW-1:0] EndMark         = 8'hFF;

    typedef enum logic [1:0] {
        ACT_CMD  = 2'd0,
        ACT_BYTE = 2'd1,
        ACT_TICK = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        KIND_TYPE    = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_DONE    = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_ENGINE  = 3'd1,
        ST_TIMEOUT = 3'd2,
        ST_START   = 3'd3,
        ST_ADDR    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_ZEROS  = 3'd1,
        PH_MARKER = 3'd2,
        PH_ADDR   = 3'd3,
        PH_STATUS = 3'd4,
        PH_LENGTH = 3'd5,
        PH_DATA   = 3'd6
    } phase_t;

    typedef struct packed {
        phase_t                phase;
        logic [ZeroCountW-1:0] zero_count;
        logic                  addr_seen;
        logic                  addr_nonzero;
        logic                  engine_failed;
        logic [ByteW-1:0]      bytes_left;
        logic                  first_pending;
        logic [TimeoutW-1:0]   idle_ticks;
    } deframe_state_t;

    typedef struct packed {
        kind_t            kind;
        logic [ByteW-1:0] value;
        logic             last;
        status_t          status;
    } result_t;

    localparam deframe_state_t StateClear = '{
        phase:         PH_IDLE,
        zero_count:    '0,
        addr_seen:     1'b0,
        addr_nonzero:  1'b0,
        engine_failed: 1'b0,
        bytes_left:    '0,
        first_pending: 1'b0,
        idle_ticks:    '0
    };

endpackage

// ===== rtl/brd_step.sv =====
// ----------------------------------------------------------------------------
// brd_step
// Next-state and result logic for one request of the response deframer.
// ----------------------------------------------------------------------------
module brd_step
    import brd_pkg::*;
(
    input  deframe_state_t              st,
    input  action_t                     action,
    input  logic                        bcast,
    input  logic [ByteW-1:0]            rx_byte,
    input  logic [TimeoutW-1:0]         timeout,
    output deframe_state_t              st_next,
    output logic                        res_valid,
    output result_t                     res
);

    logic [TimeoutW-1:0]   ticks_inc;
    logic [ZeroCountW-1:0] zeros_inc;
    logic                  nz;
    logic [ByteW-1:0]      left_dec;
    status_t               eng_status;

    assign ticks_inc  = (st.idle_ticks == TicksMax) ? st.idle_ticks
                                                    : st.idle_ticks + 1'b1;
    assign zeros_inc  = st.zero_count + 1'b1;
    assign nz         = st.addr_nonzero | (rx_byte != '0);
    assign left_dec   = (st.bytes_left != '0) ? st.bytes_left - 1'b1 : '0;
    assign eng_status = st.engine_failed ? ST_ENGINE : ST_OK;

    always_comb begin
        st_next   = st;
        res_valid = 1'b0;
        res       = '{kind: KIND_DONE, value: '0, last: 1'b1, status: ST_OK};
        unique case (action)
            ACT_CMD: begin
                st_next = StateClear;
                if (bcast) begin
                    res_valid = 1'b1;
                end else begin
                    st_next.phase = PH_ZEROS;
                end
            end
            ACT_TICK: begin
                if (st.phase != PH_IDLE) begin
                    st_next.idle_ticks = ticks_inc;
                    if (ticks_inc >= timeout) begin
                        st_next    = StateClear;
                        res_valid  = 1'b1;
                        res.status = ST_TIMEOUT;
                    end
                end
            end
            ACT_BYTE: begin
                if (st.phase != PH_IDLE) begin
                    st_next.idle_ticks = '0;
                    unique case (st.phase)
                        PH_ZEROS: begin
                            if (rx_byte != '0) begin
                                st_next    = StateClear;
                                res_valid  = 1'b1;
                                res.status = ST_START;
                            end else begin
                                st_next.zero_count = zeros_inc;
                                if (zeros_inc >= LeadZeros) begin
                                    st_next.phase = PH_MARKER;
                                end
                            end
                        end
                        PH_MARKER: begin
                            if (rx_byte != EndMark) begin
                                st_next    = StateClear;
                                res_valid  = 1'b1;
                                res.status = ST_START;
                            end else begin
                                st_next.phase = PH_ADDR;
                            end
                        end
                        PH_ADDR: begin
                            st_next.addr_nonzero = nz;
                            if (!st.addr_seen) begin
                                st_next.addr_seen = 1'b1;
                            end else if (nz) begin
                                st_next    = StateClear;
                                res_valid  = 1'b1;
                                res.status = ST_ADDR;
                            end else begin
                                st_next.phase = PH_STATUS;
                            end
                        end
                        PH_STATUS: begin
                            st_next.engine_failed = (rx_byte == '0);
                            st_next.phase         = PH_LENGTH;
                        end
                        PH_LENGTH: begin
                            if (rx_byte == '0) begin
                                st_next    = StateClear;
                                res_valid  = 1'b1;
                                res.status = eng_status;
                            end else begin
                                st_next.bytes_left    = rx_byte;
                                st_next.first_pending = 1'b1;
                                st_next.phase         = PH_DATA;
                            end
                        end
                        PH_DATA: begin
                            res_valid = 1'b1;
                            res.kind  = st.first_pending ? KIND_TYPE : KIND_PAYLOAD;
                            res.value = rx_byte;
                            if (left_dec == '0) begin
                                st_next    = StateClear;
                                res.status = eng_status;
                            end else begin
                                st_next.first_pending = 1'b0;
                                st_next.bytes_left    = left_dec;
                                res.last              = 1'b0;
                            end
                        end
                        default: begin
                            st_next = StateClear;
                        end
                    endcase
                end
            end
            default: begin
                st_next = st;
            end
        endcase
    end

endmodule

// ===== rtl/bus_response_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// bus_response_deframer_unit
// Parses the reply to a bus command and streams out its result bytes.
// ----------------------------------------------------------------------------
// Each request passes through an input register and a result register before
// its result is presented, and the block takes one request per cycle for as
// long as the result side keeps up. At most one result is produced per request.
// The timeout register should be written only while no request is in flight.
module bus_response_deframer_unit
    import brd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wen,
    input  logic [TimeoutW-1:0] cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,   // broadcast, rx_byte, zero fill
    input  logic [1:0]          s_tuser,   // action
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // value, status, zero fill
    output logic [1:0]          m_tuser,   // kind
    output logic                m_tlast
);

    logic [TimeoutW-1:0] timeout_reg;
    logic                in_valid_reg;
    action_t             in_action_reg;
    logic                in_bcast_reg;
    logic [ByteW-1:0]    in_byte_reg;
    deframe_state_t      state_reg;
    deframe_state_t      state_next;
    logic                out_valid_reg;
    result_t             out_reg;
    logic                step_valid;
    result_t             step_res;
    logic                fire;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    brd_step u_step (
        .st        (state_reg),
        .action    (in_action_reg),
        .bcast     (in_bcast_reg),
        .rx_byte   (in_byte_reg),
        .timeout   (timeout_reg),
        .st_next   (state_next),
        .res_valid (step_valid),
        .res       (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg   <= TimeoutReset;
            in_valid_reg  <= 1'b0;
            state_reg     <= StateClear;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wen) begin
                timeout_reg <= cfg_wdata;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (fire) begin
                state_reg <= state_next;
            end
            if (fire) begin
                out_valid_reg <= step_valid;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_action_reg <= action_t'(s_tuser);
            in_bcast_reg  <= s_tdata[0];
            in_byte_reg   <= s_tdata[8:1];
        end
        if (fire && step_valid) begin
            out_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.status, out_reg.value};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

endmodule

// ===== test/brd_reply_checker.sv =====
// ----------------------------------------------------------------------------
// brd_reply_checker
// Watches both streams of the bus response deframer and tracks the timeout
// register as it is written. It predicts the result of every accepted request
// and compares each delivered result, in order, with the oldest prediction.
// ----------------------------------------------------------------------------
module brd_reply_checker
    import brd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wen,
    input  logic [TimeoutW-1:0] cfg_wdata,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [15:0]         s_tdata,
    input  logic [1:0]          s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [15:0]         m_tdata,
    input  logic [1:0]          m_tuser,
    input  logic                m_tlast,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    phase_t                ph;
    logic [ZeroCountW-1:0] zeros_seen;
    logic                  addr_half;
    logic                  addr_bad;
    logic                  eng_fail;
    logic [ByteW-1:0]      remaining;
    logic                  type_next;
    logic [TimeoutW-1:0]   idle_cnt;
    logic [TimeoutW-1:0]   timeout_limit;
    result_t               replies_due[$];

    function automatic void clear_reply();
        ph         = PH_IDLE;
        zeros_seen = '0;
        addr_half  = 1'b0;
        addr_bad   = 1'b0;
        eng_fail   = 1'b0;
        remaining  = '0;
        type_next  = 1'b0;
        idle_cnt   = '0;
    endfunction

    function automatic result_t closing(input status_t s);
        clear_reply();
        return '{kind: KIND_DONE, value: '0, last: 1'b1, status: s};
    endfunction

    function automatic bit deframe_step(input logic [1:0] act, input logic bc,
                                        input logic [ByteW-1:0] b, output result_t r);
        status_t eng_status;
        r = '{kind: KIND_DONE, value: '0, last: 1'b1, status: ST_OK};
        if (act == ACT_CMD) begin
            clear_reply();
            if (bc) begin
                return 1'b1;
            end
            ph = PH_ZEROS;
            return 1'b0;
        end
        if (act == ACT_TICK) begin
            if (ph == PH_IDLE) begin
                return 1'b0;
            end
            if (idle_cnt != TicksMax) begin
                idle_cnt = idle_cnt + 1'b1;
            end
            if (idle_cnt >= timeout_limit) begin
                r = closing(ST_TIMEOUT);
                return 1'b1;
            end
            return 1'b0;
        end
        if (act != ACT_BYTE || ph == PH_IDLE) begin
            return 1'b0;
        end
        idle_cnt = '0;
        eng_status = eng_fail ? ST_ENGINE : ST_OK;
        case (ph)
            PH_ZEROS: begin
                if (b != '0) begin
                    r = closing(ST_START);
                    return 1'b1;
                end
                zeros_seen = zeros_seen + 1'b1;
                if (zeros_seen >= LeadZeros) begin
                    ph = PH_MARKER;
                end
            end
            PH_MARKER: begin
                if (b != EndMark) begin
                    r = closing(ST_START);
                    return 1'b1;
                end
                ph = PH_ADDR;
            end
            PH_ADDR: begin
                if (b != '0) begin
                    addr_bad = 1'b1;
                end
                if (!addr_half) begin
                    addr_half = 1'b1;
                end else if (addr_bad) begin
                    r = closing(ST_ADDR);
                    return 1'b1;
                end else begin
                    ph = PH_STATUS;
                end
            end
            PH_STATUS: begin
                eng_fail = (b == '0);
                ph = PH_LENGTH;
            end
            PH_LENGTH: begin
                if (b == '0) begin
                    r = closing(eng_status);
                    return 1'b1;
                end
                remaining = b;
                type_next = 1'b1;
                ph = PH_DATA;
            end
            PH_DATA: begin
                r.kind = type_next ? KIND_TYPE : KIND_PAYLOAD;
                r.value = b;
                type_next = 1'b0;
                if (remaining != '0) begin
                    remaining = remaining - 1'b1;
                end
                if (remaining == '0) begin
                    r.status = eng_status;
                    clear_reply();
                end else begin
                    r.last = 1'b0;
                end
                return 1'b1;
            end
            default: begin
                clear_reply();
            end
        endcase
        return 1'b0;
    endfunction

    always @(posedge aclk) begin
        result_t pred;
        result_t got;
        result_t want;
        if (!aresetn) begin
            clear_reply();
            timeout_limit = TimeoutReset;
            replies_due.delete();
        end else begin
            if (cfg_wen) begin
                timeout_limit = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                if (deframe_step(s_tuser, s_tdata[0], s_tdata[8:1], pred)) begin
                    replies_due.push_back(pred);
                end
            end
            if (m_tvalid && m_tready) begin
                got = '{kind: kind_t'(m_tuser), value: m_tdata[7:0], last: m_tlast,
                        status: status_t'(m_tdata[10:8])};
                if (replies_due.size() == 0) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10) begin
                        $display("%0t: unexpected result kind %0d value 0x%02h last %0b status %0d",
                                 $time, got.kind, got.value, got.last, got.status);
                    end
                end else begin
                    want = replies_due.pop_front();
                    if (got !== want || m_tdata[15:11] !== '0) begin
                        fail_count = fail_count + 1;
                        if (fail_count <= 10) begin
                            $display({"%0t: result mismatch, expected kind %0d value 0x%02h ",
                                      "last %0b status %0d, got kind %0d value 0x%02h last %0b ",
                                      "status %0d fill 0x%02h"},
                                     $time, want.kind, want.value, want.last, want.status,
                                     got.kind, got.value, got.last, got.status,
                                     m_tdata[15:11]);
                        end
                    end
                end
            end
        end
        pending = replies_due.size();
    end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives bus_response_deframer_unit with a short directed set of requests and
// then with randomized command replies: well-formed frames with random content,
// corrupted and cut-short frames, tick runs around the timeout and noise. The
// timeout register is set to values from its lowest to its highest setting, both
// stream sides stall at random, and a checker beside the block compares every
// result.
// ----------------------------------------------------------------------------
module tb;
    import brd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ActUnused  = 2'd3;
    localparam int         HoldCycles = 300;
    localparam int         CycleLimit = 1000000;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_wen   = 1'b0;
    logic [TimeoutW-1:0] cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [15:0]         s_tdata   = '0;
    logic [1:0]          s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [15:0]         m_tdata;
    logic [1:0]          m_tuser;
    logic                m_tlast;

    int fail_count;
    int pending;
    int sent          = 0;
    int cycles        = 0;
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int timeout_now   = 0;
    int hold_req      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    bus_response_deframer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    brd_reply_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("bus_response_deframer_unit verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_seen <= 0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HoldCycles;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic offer(input logic [1:0] act, input logic bc, input logic [ByteW-1:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {7'b0, b, bc};
        @(negedge aclk);
        while (!s_tready) begin
            @(negedge aclk);
        end
        @(posedge aclk);
        sent = sent + 1;
    endtask

    task automatic send_cmd(input logic bc);
        offer(ACT_CMD, bc, ByteW'($urandom_range(255)));
    endtask

    task automatic send_byte(input logic [ByteW-1:0] b);
        offer(ACT_BYTE, 1'($urandom_range(1)), b);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) begin
            offer(ACT_TICK, 1'($urandom_range(1)), ByteW'($urandom_range(255)));
        end
    endtask

    function automatic int tick_run();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 80) begin
            return 0;
        end
        if (pick < 95) begin
            return $urandom_range(1, 2);
        end
        if (timeout_now <= 40) begin
            n = timeout_now + $urandom_range(2) - 1;
            return (n < 0) ? 0 : n;
        end
        return $urandom_range(3, 8);
    endfunction

    task automatic send_reply();
        logic [ByteW-1:0] frame[$];
        int len;
        int pick;
        int cut;
        int k;
        pick = $urandom_range(99);
        if (pick < 12) begin
            len = 0;
        end else if (pick < 80) begin
            len = $urandom_range(1, 8);
        end else if (pick < 99) begin
            len = $urandom_range(9, 40);
        end else begin
            len = 255;
        end
        frame = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, EndMark, 8'h00, 8'h00};
        frame.push_back(($urandom_range(3) == 0) ? 8'h00 : ByteW'($urandom_range(1, 255)));
        frame.push_back(ByteW'(len));
        for (k = 0; k < len; k++) begin
            frame.push_back(ByteW'($urandom_range(255)));
        end
        if ($urandom_range(99) < 15) begin
            k = $urandom_range(7);
            frame[k] = frame[k] ^ ByteW'($urandom_range(1, 255));
        end
        cut = ($urandom_range(99) < 8) ? $urandom_range(frame.size() - 1) : frame.size();
        send_cmd(1'b0);
        for (k = 0; k < cut; k++) begin
            send_ticks(tick_run());
            send_byte(frame[k]);
        end
    endtask

    task automatic run_mix(input int count);
        int start;
        int pick;
        start = sent;
        while (sent - start < count) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                send_reply();
            end else if (pick < 83) begin
                send_cmd(1'b1);
            end else begin
                offer(2'($urandom_range(3)), 1'($urandom_range(1)),
                      ByteW'($urandom_range(255)));
            end
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_timeout(input logic [TimeoutW-1:0] v);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        timeout_now = v;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_timeout(16'd1);
        send_ticks(1);
        send_byte(EndMark);
        offer(ActUnused, 1'b1, 8'hFF);
        send_cmd(1'b1);
        send_cmd(1'b0);
        send_ticks(1);
        send_cmd(1'b0);
        send_byte(8'h80);
        send_cmd(1'b0);
        send_cmd(1'b1);
        send_cmd(1'b0);
        repeat (5) send_byte(8'h00);
        send_byte(EndMark);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h02);
        send_byte(8'hFF);
        send_byte(8'h00);
        settle();

        write_timeout(TimeoutW'($urandom_range(2, 12)));
        tx_idle_pct = 16;
        rx_idle_pct <= 73;
        run_mix(500);
        settle();

        write_timeout(TimeoutW'($urandom_range(13, 40)));
        tx_idle_pct = 73;
        rx_idle_pct <= 16;
        run_mix(500);
        settle();

        write_timeout(TicksMax);
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        hold_req <= hold_req + 1;
        repeat (12) send_reply();
        settle();
        run_mix(250);
        send_cmd(1'b0);
        send_ticks(40);
        settle();

        write_timeout(16'd0);
        send_cmd(1'b0);
        send_ticks(1);
        run_mix(60);
        settle();

        repeat (16) @(posedge aclk);
        @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("bus_response_deframer_unit verification clean");
        end else begin
            $display("bus_response_deframer_unit verification failed");
        end
        $finish;
    end

endmodule
